FILE: design/size_class_refcount_allocator_defines.svh
// ----------------------------------------------------------------------------
// Size class allocator assertion macros
// Shared property forms for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_REFCOUNT_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_REFCOUNT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SCRA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define SCRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: design/scra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator package
// Types, constants and size class tables shared by the allocator modules.
// ----------------------------------------------------------------------------
package scra_pkg;

  localparam int HEAP_WORDS  = 16384;
  localparam int WORD_W      = $clog2(HEAP_WORDS);
  localparam int BIG_ENTRIES = 16;
  localparam int BIG_IDX_W   = $clog2(BIG_ENTRIES);
  localparam int BIG_CNT_W   = BIG_IDX_W + 1;
  localparam int NUM_SMALL   = 8;
  localparam int CLS_W       = 3;
  localparam int TOP_W       = 7;
  localparam int PAGE_CAP    = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RETAIN  = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_READ_RC = 3'd3,
    CMD_READ_SZ = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_OOM      = 3'd2,
    ST_BAD_ADDR = 3'd3,
    ST_FREE     = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_SMALL_ALLOC,
    SRC_BIG_HIT,
    SRC_BIG_NEW,
    SRC_SMALL_OP,
    SRC_BIG_OP
  } src_t;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    carve_init;
    logic    carve_step;
    logic    pop_wr;
    logic    scan_init;
    logic    scan_step;
    logic    set_cls0;
    logic    res_we;
    status_t res_st;
    src_t    res_src;
  } dp_cmd_t;

  typedef struct packed {
    logic is_null;
    logic is_alloc;
    logic is_big_req;
    logic is_small_addr;
    logic small_bad;
    logic head_valid;
    logic heap_full;
    logic carve_last;
    logic scan_last;
    logic found;
    logic table_full;
    logic no_room;
    logic hdr_tag;
    logic clr_last;
  } dp_stat_t;

  function automatic logic [10:0] class_bytes(input logic [CLS_W-1:0] c);
    case (c)
      3'd0:    class_bytes = 11'd16;
      3'd1:    class_bytes = 11'd20;
      3'd2:    class_bytes = 11'd32;
      3'd3:    class_bytes = 11'd64;
      3'd4:    class_bytes = 11'd128;
      3'd5:    class_bytes = 11'd256;
      3'd6:    class_bytes = 11'd512;
      default: class_bytes = 11'd1024;
    endcase
  endfunction

  function automatic logic [8:0] class_step(input logic [CLS_W-1:0] c);
    case (c)
      3'd0:    class_step = 9'd4;
      3'd1:    class_step = 9'd5;
      3'd2:    class_step = 9'd8;
      3'd3:    class_step = 9'd16;
      3'd4:    class_step = 9'd32;
      3'd5:    class_step = 9'd64;
      3'd6:    class_step = 9'd128;
      default: class_step = 9'd256;
    endcase
  endfunction

  function automatic logic [5:0] class_last(input logic [CLS_W-1:0] c);
    case (c)
      3'd0:    class_last = 6'd63;
      3'd1:    class_last = 6'd50;
      3'd2:    class_last = 6'd31;
      3'd3:    class_last = 6'd15;
      3'd4:    class_last = 6'd7;
      3'd5:    class_last = 6'd3;
      3'd6:    class_last = 6'd1;
      default: class_last = 6'd0;
    endcase
  endfunction

  function automatic logic [CLS_W-1:0] small_class(input logic [16:0] need);
    if (need <= 17'd16)       small_class = 3'd0;
    else if (need <= 17'd20)  small_class = 3'd1;
    else if (need <= 17'd32)  small_class = 3'd2;
    else if (need <= 17'd64)  small_class = 3'd3;
    else if (need <= 17'd128) small_class = 3'd4;
    else if (need <= 17'd256) small_class = 3'd5;
    else if (need <= 17'd512) small_class = 3'd6;
    else                      small_class = 3'd7;
  endfunction

  function automatic logic [7:0] rc_update(input logic [2:0] cmd, input logic [7:0] cur);
    rc_update = cur;
    if (cur != 8'd255) begin
      if (cmd == CMD_RETAIN) rc_update = cur + 8'd1;
      else if (cmd == CMD_RELEASE) rc_update = cur - 8'd1;
    end
  endfunction

endpackage

FILE: design/scra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each command through the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
`include "size_class_refcount_allocator_defines.svh"

module scra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output scra_pkg::dp_cmd_t  cmd,
  input  scra_pkg::dp_stat_t stat
);
  import scra_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_ACHK   = 10'b0000001000,
    S_CARVE  = 10'b0000010000,
    S_POPW   = 10'b0000100000,
    S_BSCAN  = 10'b0001000000,
    S_BEVAL  = 10'b0010000000,
    S_BNEW   = 10'b0100000000,
    S_FWAIT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   alloc_big, alloc_big_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_st     = ST_OK;
    cmd.res_src    = SRC_NONE;
    state_next     = state;
    alloc_big_next = alloc_big;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          alloc_big_next = 1'b0;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_null) begin
          cmd.res_we = 1'b1;
          cmd.res_st = ST_NULL;
          state_next = S_IDLE;
        end else if (stat.is_alloc) begin
          if (stat.is_big_req) begin
            cmd.scan_init = 1'b1;
            state_next    = S_BSCAN;
          end else begin
            state_next = S_ACHK;
          end
        end else if (stat.is_small_addr) begin
          if (stat.small_bad) begin
            cmd.res_we = 1'b1;
            cmd.res_st = ST_BAD_ADDR;
            state_next = S_IDLE;
          end else begin
            state_next = S_FWAIT;
          end
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_BSCAN;
        end
      end
      S_ACHK: begin
        if (stat.head_valid) begin
          state_next = S_POPW;
        end else if (stat.heap_full) begin
          cmd.res_we = 1'b1;
          cmd.res_st = ST_OOM;
          state_next = S_IDLE;
        end else begin
          cmd.carve_init = 1'b1;
          state_next     = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (stat.carve_last) state_next = S_ACHK;
      end
      S_POPW: begin
        cmd.pop_wr = 1'b1;
        if (alloc_big) begin
          state_next = S_BNEW;
        end else begin
          cmd.res_we  = 1'b1;
          cmd.res_src = SRC_SMALL_ALLOC;
          state_next  = S_IDLE;
        end
      end
      S_BSCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_BEVAL;
      end
      S_BEVAL: begin
        if (stat.is_alloc) begin
          if (stat.found) begin
            cmd.res_we  = 1'b1;
            cmd.res_src = SRC_BIG_HIT;
            state_next  = S_IDLE;
          end else if (stat.table_full) begin
            cmd.res_we = 1'b1;
            cmd.res_st = ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.set_cls0   = 1'b1;
            alloc_big_next = 1'b1;
            state_next     = S_ACHK;
          end
        end else begin
          cmd.res_we = 1'b1;
          state_next = S_IDLE;
          if (stat.found) cmd.res_src = SRC_BIG_OP;
          else cmd.res_st = ST_BAD_ADDR;
        end
      end
      S_BNEW: begin
        cmd.res_we = 1'b1;
        state_next = S_IDLE;
        if (stat.no_room) cmd.res_st = ST_OOM;
        else cmd.res_src = SRC_BIG_NEW;
      end
      S_FWAIT: begin
        cmd.res_we = 1'b1;
        state_next = S_IDLE;
        if (stat.hdr_tag) cmd.res_src = SRC_SMALL_OP;
        else cmd.res_st = ST_BAD_ADDR;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      alloc_big <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      alloc_big <= alloc_big_next;
      done      <= cmd.res_we;
    end
  end

  `SCRA_ASSERT_NEXT(a_strobe_single, done, !done)
  `SCRA_ASSERT_NEXT(a_accept_decodes, start && !busy, state == S_DECODE)
  `SCRA_ASSERT_SAME(a_lookup_not_big_alloc, state == S_FWAIT, !alloc_big)
  `SCRA_ASSERT_SAME(a_no_strobe_in_clear, state == S_CLEAR, !done)

endmodule

FILE: design/scra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Chunk memories, free list heads, big block table and result registers.
// ----------------------------------------------------------------------------
module scra_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [2:0]                          command,
  input  logic [15:0]                         request_bytes,
  input  logic [19:0]                         block_address,
  input  logic                                write_enable,
  input  logic [scra_pkg::CFG_IDX_W-1:0]      write_index,
  input  logic [scra_pkg::CFG_DATA_W-1:0]     write_data,
  input  scra_pkg::dp_cmd_t                   cmd,
  output scra_pkg::dp_stat_t                  stat,
  output logic [2:0]                          status,
  output logic [19:0]                         address,
  output logic [7:0]                          refcount,
  output logic [16:0]                         size_bytes
);
  import scra_pkg::*;

  logic [9:0]        base_kb;
  logic [6:0]        size_kb;
  logic [TOP_W-1:0]  heap_top;
  logic [2:0]        cmd_r;
  logic [15:0]       n_r;
  logic [19:0]       addr_r;
  logic [6:0]        kb_r;
  logic [CLS_W-1:0]  cls_r;

  logic [NUM_SMALL-1:0] head_valid;
  logic [WORD_W-1:0]    head_idx [NUM_SMALL];

  logic [11:0]       hdr_mem [HEAP_WORDS];
  logic [WORD_W-1:0] link_mem [HEAP_WORDS];
  logic [11:0]       hdr_q;
  logic [WORD_W-1:0] link_q;
  logic              hdr_we, lnk_we;
  logic [WORD_W-1:0] hdr_wa, lnk_wa, lnk_wd;
  logic [11:0]       hdr_wd;
  logic [WORD_W-1:0] clr_cnt;

  logic [WORD_W-1:0] at_r;
  logic [5:0]        k_r;

  logic [BIG_ENTRIES-1:0] bv;
  logic [6:0]             bsz [BIG_ENTRIES];
  logic [5:0]             bpg [BIG_ENTRIES];
  logic [7:0]             brc [BIG_ENTRIES];
  logic [BIG_IDX_W-1:0]   idx_r, hit_r, pos_r, pos_ins;
  logic [BIG_CNT_W-1:0]   cnt_r;
  logic                   found_r, posf_r;

  status_t     st_r;
  logic [19:0] ra_r;
  logic [7:0]  rc_r;
  logic [16:0] sz_r;

  logic [19:0]       base;
  logic [6:0]        page_cap;
  logic [16:0]       need;
  logic [19:0]       off;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] pop_p;
  logic [WORD_W-1:0] first;
  logic [8:0]        step;
  logic              carve_last;
  logic              is_mod;
  logic [7:0]        h_cur, h_new, b_cur, b_new;
  logic [CLS_W-1:0]  h_cls;
  logic              s_err, s_free_now, b_err;
  logic              small_op, big_op, big_new;
  logic [19:0]       scan_addr;
  logic              in_fit, pos_fit;

  assign base     = {base_kb, 10'd0};
  assign page_cap = (size_kb < 7'(PAGE_CAP)) ? size_kb : 7'(PAGE_CAP);
  assign need     = {1'b0, n_r} + 17'd4;
  assign off      = addr_r - base;
  assign word     = off[WORD_W+1:2] - 1'b1;
  assign pop_p    = head_idx[cls_r];
  assign first    = {heap_top[5:0], 8'd0};
  assign step     = class_step(cls_r);
  assign carve_last = (k_r == class_last(cls_r));
  assign is_mod   = (cmd_r == CMD_RETAIN) || (cmd_r == CMD_RELEASE);
  assign h_cur    = hdr_q[7:0];
  assign h_cls    = hdr_q[10:8];
  assign h_new    = rc_update(cmd_r, h_cur);
  assign b_cur    = brc[hit_r];
  assign b_new    = rc_update(cmd_r, b_cur);
  assign s_err    = is_mod && (h_cur == 8'd0);
  assign b_err    = is_mod && (b_cur == 8'd0);
  assign small_op = cmd.res_we && (cmd.res_src == SRC_SMALL_OP);
  assign big_op   = cmd.res_we && (cmd.res_src == SRC_BIG_OP);
  assign big_new  = cmd.res_we && (cmd.res_src == SRC_BIG_NEW);
  assign s_free_now = small_op && !s_err && (cmd_r == CMD_RELEASE) && (h_new == 8'd0);
  assign scan_addr = base + {4'd0, bpg[idx_r], 10'd0};
  assign in_fit   = bsz[idx_r] >= kb_r;
  assign pos_fit  = posf_r ? 1'b0 : 1'b1;
  assign pos_ins  = posf_r ? pos_r : cnt_r[BIG_IDX_W-1:0];

  always_comb begin
    stat               = '0;
    stat.is_alloc      = (cmd_r == CMD_ALLOC);
    stat.is_null       = (cmd_r == CMD_ALLOC) ? (n_r == 16'd0)
                         : ((cmd_r > CMD_READ_SZ) || (addr_r == 20'd0));
    stat.is_big_req    = need > 17'd1024;
    stat.is_small_addr = addr_r[9:0] != 10'd0;
    stat.small_bad     = (off[19:10] >= {3'd0, heap_top}) || (off[1:0] != 2'd0)
                         || (off < 20'd4);
    stat.head_valid    = head_valid[cls_r];
    stat.heap_full     = heap_top >= page_cap;
    stat.carve_last    = carve_last;
    stat.scan_last     = (idx_r == {BIG_IDX_W{1'b1}});
    stat.found         = found_r;
    stat.table_full    = cnt_r >= BIG_CNT_W'(BIG_ENTRIES);
    stat.no_room       = ({1'b0, heap_top} + {1'b0, kb_r}) > {1'b0, page_cap};
    stat.hdr_tag       = hdr_q[11];
    stat.clr_last      = (clr_cnt == {WORD_W{1'b1}});
  end

  always_comb begin
    hdr_we = 1'b0;
    hdr_wa = word;
    hdr_wd = '0;
    lnk_we = 1'b0;
    lnk_wa = at_r;
    lnk_wd = carve_last ? at_r : at_r + WORD_W'(step);
    if (cmd.clr_step) begin
      hdr_we = 1'b1;
      hdr_wa = clr_cnt;
    end
    if (cmd.pop_wr) begin
      hdr_we = 1'b1;
      hdr_wa = pop_p;
      hdr_wd = {1'b1, cls_r, 8'd1};
    end
    if (cmd.carve_step) lnk_we = 1'b1;
    if (small_op && !s_err && is_mod) begin
      hdr_we = 1'b1;
      hdr_wd = {hdr_q[11:8], h_new};
    end
    if (s_free_now) begin
      lnk_we = 1'b1;
      lnk_wa = word;
      lnk_wd = head_valid[h_cls] ? head_idx[h_cls] : word;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_q <= hdr_mem[word];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) link_mem[lnk_wa] <= lnk_wd;
    link_q <= link_mem[pop_p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_kb    <= 10'd1;
      size_kb    <= 7'd64;
      heap_top   <= '0;
      head_valid <= '0;
      bv         <= '0;
      clr_cnt    <= '0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_BASE: base_kb <= write_data;
          REG_SIZE: size_kb <= write_data[6:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.carve_step && carve_last) begin
        head_valid[cls_r] <= 1'b1;
        heap_top          <= heap_top + 1'b1;
      end
      if (cmd.pop_wr) head_valid[cls_r] <= (link_q != pop_p);
      if (s_free_now) head_valid[h_cls] <= 1'b1;
      if (big_new) begin
        heap_top <= heap_top + kb_r;
        for (int i = 1; i < BIG_ENTRIES; i++) begin
          if (BIG_IDX_W'(i) > pos_ins) bv[i] <= bv[i-1];
        end
        bv[pos_ins] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= command;
      n_r    <= request_bytes;
      addr_r <= block_address;
      kb_r   <= 7'(({1'b0, request_bytes} + 17'd1023) >> 10);
      cls_r  <= small_class({1'b0, request_bytes} + 17'd4);
    end
    if (cmd.set_cls0) cls_r <= '0;
    if (cmd.carve_init) begin
      at_r <= first;
      k_r  <= '0;
    end
    if (cmd.carve_step) begin
      at_r <= at_r + WORD_W'(step);
      k_r  <= k_r + 1'b1;
      if (carve_last) head_idx[cls_r] <= first;
    end
    if (cmd.pop_wr) head_idx[cls_r] <= link_q;
    if (s_free_now) head_idx[h_cls] <= word;

    if (cmd.scan_init) begin
      idx_r   <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
      posf_r  <= 1'b0;
      hit_r   <= '0;
      pos_r   <= '0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (bv[idx_r]) begin
        if (cmd_r == CMD_ALLOC) begin
          cnt_r <= cnt_r + 1'b1;
          if (!found_r && (brc[idx_r] == 8'd0) && in_fit) begin
            found_r <= 1'b1;
            hit_r   <= idx_r;
          end
          if (pos_fit && in_fit) begin
            posf_r <= 1'b1;
            pos_r  <= idx_r;
          end
        end else if (!found_r && (scan_addr == addr_r)) begin
          found_r <= 1'b1;
          hit_r   <= idx_r;
        end
      end
    end

    if (big_new) begin
      for (int i = 1; i < BIG_ENTRIES; i++) begin
        if (BIG_IDX_W'(i) > pos_ins) begin
          bsz[i] <= bsz[i-1];
          bpg[i] <= bpg[i-1];
          brc[i] <= brc[i-1];
        end
      end
      bsz[pos_ins] <= kb_r;
      bpg[pos_ins] <= heap_top[5:0];
      brc[pos_ins] <= 8'd1;
    end
    if (cmd.res_we && (cmd.res_src == SRC_BIG_HIT)) brc[hit_r] <= 8'd1;
    if (big_op && !b_err) brc[hit_r] <= b_new;

    if (cmd.res_we) begin
      st_r <= cmd.res_st;
      ra_r <= '0;
      rc_r <= '0;
      sz_r <= '0;
      case (cmd.res_src)
        SRC_SMALL_ALLOC: begin
          ra_r <= base + {4'd0, pop_p, 2'd0} + 20'd4;
          rc_r <= 8'd1;
        end
        SRC_BIG_HIT: begin
          ra_r <= base + {4'd0, bpg[hit_r], 10'd0};
          rc_r <= 8'd1;
        end
        SRC_BIG_NEW: begin
          ra_r <= base + {4'd0, heap_top[5:0], 10'd0};
          rc_r <= 8'd1;
        end
        SRC_SMALL_OP: begin
          if (s_err) begin
            st_r <= ST_FREE;
          end else begin
            rc_r <= h_new;
            if (cmd_r == CMD_READ_SZ) sz_r <= {6'd0, class_bytes(h_cls) - 11'd4};
          end
        end
        SRC_BIG_OP: begin
          if (b_err) begin
            st_r <= ST_FREE;
          end else begin
            rc_r <= b_new;
            if (cmd_r == CMD_READ_SZ) sz_r <= {bsz[hit_r], 10'd0};
          end
        end
        default: ;
      endcase
    end
  end

  assign status     = st_r;
  assign address    = ra_r;
  assign refcount   = rc_r;
  assign size_bytes = sz_r;

endmodule

FILE: design/size_class_refcount_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class reference counted allocator
// Segregated free list heap allocator with per-block reference counts.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command gives
// exactly one result, shown for one cycle with done high; the receiver has no
// way to hold it off, and the next command may be started in that cycle.
// The user must write the configuration registers through write_enable,
// write_index and write_data only while idle; the block does not enforce it.
// A null, a misplaced small address, a small lookup or an allocate from a
// nonempty free list ends with no walk or scan. A refill walks the new page
// once per chunk. Big blocks are found by a serial scan of the 16 table
// entries, one entry a cycle, and a new big block then also takes the small
// allocate path.
// After reset the chunk header memory is cleared one word a cycle, which
// keeps busy high until all 16384 words are cleared.
// ----------------------------------------------------------------------------
module size_class_refcount_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      command,
  input  logic [15:0]                     request_bytes,
  input  logic [19:0]                     block_address,
  input  logic                            write_enable,
  input  logic [scra_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [scra_pkg::CFG_DATA_W-1:0] write_data,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [19:0]                     address,
  output logic [7:0]                      refcount,
  output logic [16:0]                     size_bytes
);
  import scra_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  scra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (dcmd),
    .stat  (dstat)
  );

  scra_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (command),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .write_enable  (write_enable),
    .write_index   (write_index),
    .write_data    (write_data),
    .cmd           (dcmd),
    .stat          (dstat),
    .status        (status),
    .address       (address),
    .refcount      (refcount),
    .size_bytes    (size_bytes)
  );

endmodule
